// ===== design/pdre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdre_pkg
// Shared widths, item codes, register indexes and the control/status structs
// of the polyline delta run encoder.
// ----------------------------------------------------------------------------
package pdre_pkg;

    // run limit and derived widths
    localparam int MAX_RUN    = 32;
    localparam int CNT_W      = 6;
    localparam int IDX_W      = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int COORD_W    = 32;
    localparam int DELTA_W    = 8;
    localparam int TARGET_W   = 16;
    localparam int VALUE_W    = 8;
    localparam int CODE_W     = 16;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // item kinds on the output word
    localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELTA  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LONG   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_VALUE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_CODE   = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic emit_hdr;
        logic emit_dlt;
        logic emit_long;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic have_prev;
        logic step_short;
        logic run_close;
        logic run_open;
        logic idx_at_end;
        logic long_pend;
        logic out_free;
    } t_status;

    // one result word
    typedef struct packed {
        logic [KIND_W-1:0]          item_kind;
        logic signed [COORD_W-1:0]  start_x;
        logic signed [COORD_W-1:0]  start_y;
        logic signed [COORD_W-1:0]  end_x;
        logic signed [COORD_W-1:0]  end_y;
        logic [CNT_W-1:0]           run_length;
        logic signed [DELTA_W-1:0]  delta_x;
        logic signed [DELTA_W-1:0]  delta_y;
        logic [TARGET_W-1:0]        header_target;
        logic [VALUE_W-1:0]         header_value;
        logic [CODE_W-1:0]          header_code;
        logic                       last_of_burst;
    } t_item;

endpackage

// ===== design/pdre_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdre interfaces
// Vertex, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pdre_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [pdre_pkg::COORD_W-1:0] point_x;
    logic signed [pdre_pkg::COORD_W-1:0] point_y;
    logic                               last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input last_point,
                    output ready);
endinterface

interface pdre_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [pdre_pkg::KIND_W-1:0]          item_kind;
    logic signed [pdre_pkg::COORD_W-1:0]  start_x;
    logic signed [pdre_pkg::COORD_W-1:0]  start_y;
    logic signed [pdre_pkg::COORD_W-1:0]  end_x;
    logic signed [pdre_pkg::COORD_W-1:0]  end_y;
    logic [pdre_pkg::CNT_W-1:0]           run_length;
    logic signed [pdre_pkg::DELTA_W-1:0]  delta_x;
    logic signed [pdre_pkg::DELTA_W-1:0]  delta_y;
    logic [pdre_pkg::TARGET_W-1:0]        header_target;
    logic [pdre_pkg::VALUE_W-1:0]         header_value;
    logic [pdre_pkg::CODE_W-1:0]          header_code;
    logic                                 last_of_burst;

    modport source (output valid, output item_kind, output start_x, output start_y,
                    output end_x, output end_y, output run_length, output delta_x,
                    output delta_y, output header_target, output header_value,
                    output header_code, output last_of_burst, input ready);
    modport sink   (input valid, input item_kind, input start_x, input start_y,
                    input end_x, input end_y, input run_length, input delta_x,
                    input delta_y, input header_target, input header_value,
                    input header_code, input last_of_burst, output ready);
endinterface

interface pdre_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pdre_pkg::CFG_IDX_W-1:0]    index;
    logic [pdre_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/pdre_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdre_ctrl
// Sequencer: takes a vertex, then walks header, delta words and long segment.
// ----------------------------------------------------------------------------
module pdre_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pdre_pkg::t_status i_status,
    output pdre_pkg::t_cmd    o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HDR  = 2'd1;
    localparam logic [1:0] ST_DLT  = 2'd2;
    localparam logic [1:0] ST_LONG = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == ST_IDLE);

    // next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid && i_status.have_prev) begin
                    if (i_status.step_short) begin
                        if (i_status.run_close) n_state = ST_HDR;
                    end else if (i_status.run_open) begin
                        n_state = ST_HDR;
                    end else begin
                        n_state = ST_LONG;
                    end
                end
            end
            ST_HDR: begin
                if (i_status.out_free) begin
                    o_cmd.emit_hdr = 1'b1;
                    n_state        = ST_DLT;
                end
            end
            ST_DLT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_dlt = 1'b1;
                    if (i_status.idx_at_end) begin
                        n_state = i_status.long_pend ? ST_LONG : ST_IDLE;
                    end
                end
            end
            ST_LONG: begin
                if (i_status.out_free) begin
                    o_cmd.emit_long = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/pdre_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdre_dp
// Datapath: vertex history, step classification, delta store, config
// registers and the output word register.
// ----------------------------------------------------------------------------
module pdre_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic signed [pdre_pkg::COORD_W-1:0]   i_point_x,
    input  logic signed [pdre_pkg::COORD_W-1:0]   i_point_y,
    input  logic                                  i_last_point,
    input  logic                                  i_cfg_valid,
    input  logic [pdre_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pdre_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  pdre_pkg::t_cmd                        i_cmd,
    output pdre_pkg::t_status                     o_status,
    output pdre_pkg::t_item                       o_item,
    output logic                                  o_item_valid,
    input  logic                                  i_item_ready
);

    localparam int STEP_W = pdre_pkg::COORD_W + 1;
    localparam int SGN_W  = STEP_W - pdre_pkg::DELTA_W + 1;

    // config registers
    logic [pdre_pkg::TARGET_W-1:0] r_target_id;
    logic [pdre_pkg::VALUE_W-1:0]  r_pixel_value;
    logic [pdre_pkg::CODE_W-1:0]   r_draw_code;

    // vertex and run state
    logic                                 r_have_prev;
    logic signed [pdre_pkg::COORD_W-1:0]  r_prev_x;
    logic signed [pdre_pkg::COORD_W-1:0]  r_prev_y;
    logic signed [pdre_pkg::COORD_W-1:0]  r_run_x;
    logic signed [pdre_pkg::COORD_W-1:0]  r_run_y;
    logic signed [pdre_pkg::COORD_W-1:0]  r_seg_sx;
    logic signed [pdre_pkg::COORD_W-1:0]  r_seg_sy;
    logic signed [pdre_pkg::COORD_W-1:0]  r_seg_ex;
    logic signed [pdre_pkg::COORD_W-1:0]  r_seg_ey;
    logic [pdre_pkg::CNT_W-1:0]           r_count;
    logic [pdre_pkg::CNT_W-1:0]           r_flush_len;
    logic                                 r_long_pend;
    logic [pdre_pkg::IDX_W-1:0]           r_idx;
    logic [pdre_pkg::IDX_W-1:0]           n_idx;

    // delta store
    logic [2*pdre_pkg::DELTA_W-1:0] r_mem [pdre_pkg::MAX_RUN];
    logic [2*pdre_pkg::DELTA_W-1:0] r_rd_data;

    // output word
    pdre_pkg::t_item r_out;
    pdre_pkg::t_item n_out;
    logic            r_out_valid;

    // step classification on 33 bits
    logic signed [STEP_W-1:0]     step_x;
    logic signed [STEP_W-1:0]     step_y;
    logic                         short_x;
    logic                         short_y;
    logic [pdre_pkg::CNT_W-1:0]   count_inc;
    logic                         emit;

    assign step_x  = STEP_W'(i_point_x) - STEP_W'(r_prev_x);
    assign step_y  = STEP_W'(i_point_y) - STEP_W'(r_prev_y);
    assign short_x = (step_x[STEP_W-1:pdre_pkg::DELTA_W-1] == '0) ||
                     (step_x[STEP_W-1:pdre_pkg::DELTA_W-1] == {SGN_W{1'b1}});
    assign short_y = (step_y[STEP_W-1:pdre_pkg::DELTA_W-1] == '0) ||
                     (step_y[STEP_W-1:pdre_pkg::DELTA_W-1] == {SGN_W{1'b1}});
    assign count_inc = r_count + pdre_pkg::CNT_W'(1);
    assign emit      = i_cmd.emit_hdr | i_cmd.emit_dlt | i_cmd.emit_long;

    // status back to the controller
    always_comb begin
        o_status.have_prev  = r_have_prev;
        o_status.step_short = short_x & short_y;
        o_status.run_close  = (count_inc == pdre_pkg::CNT_W'(pdre_pkg::MAX_RUN)) |
                              i_last_point;
        o_status.run_open   = (r_count != '0);
        o_status.idx_at_end = ((pdre_pkg::CNT_W'(r_idx) + pdre_pkg::CNT_W'(1)) ==
                               r_flush_len);
        o_status.long_pend  = r_long_pend;
        o_status.out_free   = !r_out_valid || i_item_ready;
    end

    // config writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_id   <= '0;
            r_pixel_value <= '0;
            r_draw_code   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pdre_pkg::CFG_TARGET_ID:   r_target_id   <= i_cfg_data;
                pdre_pkg::CFG_PIXEL_VALUE: r_pixel_value <= i_cfg_data[pdre_pkg::VALUE_W-1:0];
                pdre_pkg::CFG_DRAW_CODE:   r_draw_code   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // vertex history and run bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_run_x     <= '0;
            r_run_y     <= '0;
            r_count     <= '0;
            r_flush_len <= '0;
            r_long_pend <= 1'b0;
        end else if (i_cmd.accept) begin
            r_prev_x <= i_point_x;
            r_prev_y <= i_point_y;
            if (!r_have_prev) begin
                r_run_x     <= i_point_x;
                r_run_y     <= i_point_y;
                r_count     <= '0;
                r_have_prev <= !i_last_point;
            end else begin
                r_long_pend <= !(short_x && short_y);
                if (short_x && short_y) begin
                    if (r_count == '0) begin
                        r_run_x <= r_prev_x;
                        r_run_y <= r_prev_y;
                    end
                    if (o_status.run_close) begin
                        r_flush_len <= count_inc;
                        r_count     <= '0;
                    end else begin
                        r_count <= count_inc;
                    end
                end else begin
                    r_flush_len <= r_count;
                    r_count     <= '0;
                end
                if (i_last_point) begin
                    r_have_prev <= 1'b0;
                    r_count     <= '0;
                end
            end
        end
    end

    // long segment end points
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_seg_sx <= r_prev_x;
            r_seg_sy <= r_prev_y;
            r_seg_ex <= i_point_x;
            r_seg_ey <= i_point_y;
        end
    end

    // delta read index, read data always tracks the index
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.emit_hdr) begin
            n_idx = '0;
        end else if (i_cmd.emit_dlt) begin
            n_idx = o_status.idx_at_end ? '0 : r_idx + pdre_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    // delta store write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && r_have_prev && short_x && short_y) begin
            r_mem[r_count[pdre_pkg::IDX_W-1:0]] <= {step_y[pdre_pkg::DELTA_W-1:0],
                                                    step_x[pdre_pkg::DELTA_W-1:0]};
        end
        r_rd_data <= r_mem[n_idx];
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_item_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // next output word, unused fields zero
    always_comb begin
        n_out = '0;
        if (i_cmd.emit_hdr) begin
            n_out.item_kind     = pdre_pkg::KIND_HEADER;
            n_out.start_x       = r_run_x;
            n_out.start_y       = r_run_y;
            n_out.run_length    = r_flush_len;
            n_out.header_target = r_target_id;
            n_out.header_value  = r_pixel_value;
            n_out.header_code   = r_draw_code;
        end else if (i_cmd.emit_dlt) begin
            n_out.item_kind     = pdre_pkg::KIND_DELTA;
            n_out.delta_x       = r_rd_data[pdre_pkg::DELTA_W-1:0];
            n_out.delta_y       = r_rd_data[2*pdre_pkg::DELTA_W-1:pdre_pkg::DELTA_W];
            n_out.last_of_burst = o_status.idx_at_end && !r_long_pend;
        end else if (i_cmd.emit_long) begin
            n_out.item_kind     = pdre_pkg::KIND_LONG;
            n_out.start_x       = r_seg_sx;
            n_out.start_y       = r_seg_sy;
            n_out.end_x         = r_seg_ex;
            n_out.end_y         = r_seg_ey;
            n_out.header_value  = r_pixel_value;
            n_out.header_code   = r_draw_code;
            n_out.last_of_burst = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_item       = r_out;
    assign o_item_valid = r_out_valid;

endmodule

// ===== design/polyline_delta_run_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_delta_run_encoder
// Packs polyline vertices into run headers, byte delta words and long
// segment words.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          words
//  i_pt      in    valid/ready        one vertex
//  o_item    out   valid/ready        header, delta or long segment
//  i_cfg     in    valid/ready(=1)    register index and data
//
//  A vertex that causes no result is taken and the sequencer stays idle. A
//  vertex that flushes a run of n deltas gives a header, then one delta word
//  a cycle from the delta store while the sink is free, then any long segment;
//  a lone long segment gives one word. The output register frees the block
//  from the sink for one word; a stalled sink holds the sequencer in place.
//  Reset is synchronous active low; the delta store needs no clearing.
// ----------------------------------------------------------------------------
module polyline_delta_run_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pdre_in_if.sink     i_pt,
    pdre_out_if.source  o_item,
    pdre_cfg_if.sink    i_cfg
);

    pdre_pkg::t_cmd    cmd;
    pdre_pkg::t_status status;
    pdre_pkg::t_item   item;
    logic              item_valid;

    // sequencer
    pdre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pt.valid),
        .o_in_ready (i_pt.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath
    pdre_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_point_x    (i_pt.point_x),
        .i_point_y    (i_pt.point_y),
        .i_last_point (i_pt.last_point),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_index  (i_cfg.index),
        .i_cfg_data   (i_cfg.data),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_ready (o_item.ready)
    );

    // config always taken
    assign i_cfg.ready = 1'b1;

    // result word out
    assign o_item.valid         = item_valid;
    assign o_item.item_kind     = item.item_kind;
    assign o_item.start_x       = item.start_x;
    assign o_item.start_y       = item.start_y;
    assign o_item.end_x         = item.end_x;
    assign o_item.end_y         = item.end_y;
    assign o_item.run_length    = item.run_length;
    assign o_item.delta_x       = item.delta_x;
    assign o_item.delta_y       = item.delta_y;
    assign o_item.header_target = item.header_target;
    assign o_item.header_value  = item.header_value;
    assign o_item.header_code   = item.header_code;
    assign o_item.last_of_burst = item.last_of_burst;

    // at most one word loaded per cycle
    a_one_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.emit_hdr, cmd.emit_dlt, cmd.emit_long}))
        else $error("more than one output word loaded");

    // a header always announces at least one delta
    a_hdr_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_item.valid && o_item.item_kind == pdre_pkg::KIND_HEADER) |->
        (o_item.run_length != '0))
        else $error("empty run header");

    // no vertex taken while deltas of a header are still owed
    a_hdr_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit_hdr |=> !i_pt.ready)
        else $error("vertex accepted during run flush");

    // a header word never closes a burst
    a_hdr_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_item.valid && o_item.item_kind == pdre_pkg::KIND_HEADER) |->
        !o_item.last_of_burst)
        else $error("header marked as last word");

endmodule

// ===== bench/pdre_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdre_checker
// Watches the vertex, configuration and result channels of the polyline delta
// run encoder. Predicts the result words of every accepted vertex and compares
// each accepted result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module pdre_checker
    import pdre_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    pdre_in_if   i_pt,
    pdre_out_if  i_item,
    pdre_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_outstanding
);

    // register copies
    logic [TARGET_W-1:0] target_id_r;
    logic [VALUE_W-1:0]  pixel_value_r;
    logic [CODE_W-1:0]   draw_code_r;

    // encoder state
    logic                      have_prev;
    logic signed [COORD_W-1:0] prev_x;
    logic signed [COORD_W-1:0] prev_y;
    logic signed [COORD_W-1:0] run_x;
    logic signed [COORD_W-1:0] run_y;
    int unsigned               run_len;
    logic [2*DELTA_W-1:0]      step_store [MAX_RUN];

    // predicted words, oldest first, and the words of the vertex in hand
    t_item expected_words[$];
    t_item burst_words[$];

    int mismatches = 0;
    int words_seen = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] word %0d: %s", $time, words_seen, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task automatic compare_word(input t_item got, input t_item want);
        check_field("item_kind",     32'(got.item_kind),     32'(want.item_kind));
        check_field("start_x",       got.start_x,            want.start_x);
        check_field("start_y",       got.start_y,            want.start_y);
        check_field("end_x",         got.end_x,              want.end_x);
        check_field("end_y",         got.end_y,              want.end_y);
        check_field("run_length",    32'(got.run_length),    32'(want.run_length));
        check_field("delta_x",       32'(got.delta_x),       32'(want.delta_x));
        check_field("delta_y",       32'(got.delta_y),       32'(want.delta_y));
        check_field("header_target", 32'(got.header_target), 32'(want.header_target));
        check_field("header_value",  32'(got.header_value),  32'(want.header_value));
        check_field("header_code",   32'(got.header_code),   32'(want.header_code));
        check_field("last_of_burst", 32'(got.last_of_burst), 32'(want.last_of_burst));
    endtask

    // header then one delta word per buffered step
    function automatic void close_run();
        t_item w;
        if (run_len == 0)
            return;
        w               = '0;
        w.item_kind     = KIND_HEADER;
        w.start_x       = run_x;
        w.start_y       = run_y;
        w.run_length    = run_len[CNT_W-1:0];
        w.header_target = target_id_r;
        w.header_value  = pixel_value_r;
        w.header_code   = draw_code_r;
        burst_words.push_back(w);
        for (int i = 0; i < run_len; i++) begin
            w           = '0;
            w.item_kind = KIND_DELTA;
            w.delta_x   = step_store[i][DELTA_W-1:0];
            w.delta_y   = step_store[i][2*DELTA_W-1:DELTA_W];
            burst_words.push_back(w);
        end
        run_len = 0;
    endfunction

    // words caused by one vertex
    function automatic void encode_vertex(input logic signed [COORD_W-1:0] x,
                                          input logic signed [COORD_W-1:0] y,
                                          input logic last);
        logic signed [COORD_W:0] wide_x, wide_y, wide_px, wide_py, dx, dy;
        t_item w;
        burst_words.delete();
        if (!have_prev) begin
            prev_x    = x;
            prev_y    = y;
            run_x     = x;
            run_y     = y;
            run_len   = 0;
            have_prev = !last;
            return;
        end
        // steps on one extra bit so a wrapped difference cannot look short
        wide_x  = (COORD_W+1)'(x);
        wide_y  = (COORD_W+1)'(y);
        wide_px = (COORD_W+1)'(prev_x);
        wide_py = (COORD_W+1)'(prev_y);
        dx = wide_x - wide_px;
        dy = wide_y - wide_py;
        if (dx >= -128 && dx <= 127 && dy >= -128 && dy <= 127) begin
            if (run_len == 0) begin
                run_x = prev_x;
                run_y = prev_y;
            end
            if (run_len < MAX_RUN) begin
                step_store[run_len] = {dy[DELTA_W-1:0], dx[DELTA_W-1:0]};
                run_len++;
            end
            if (run_len >= MAX_RUN)
                close_run();
        end else begin
            close_run();
            w              = '0;
            w.item_kind    = KIND_LONG;
            w.start_x      = prev_x;
            w.start_y      = prev_y;
            w.end_x        = x;
            w.end_y        = y;
            w.header_value = pixel_value_r;
            w.header_code  = draw_code_r;
            burst_words.push_back(w);
        end
        prev_x = x;
        prev_y = y;
        if (last) begin
            close_run();
            have_prev = 1'b0;
            run_len   = 0;
        end
        // mark the final word of this vertex
        if (burst_words.size() > 0) begin
            w = burst_words[burst_words.size()-1];
            w.last_of_burst = 1'b1;
            burst_words[burst_words.size()-1] = w;
        end
        foreach (burst_words[i])
            expected_words.push_back(burst_words[i]);
    endfunction

    // sample all channels at the clock edge
    always @(posedge i_clk) begin : watch
        t_item seen;
        t_item want;
        if (!i_rst_n) begin
            target_id_r   = '0;
            pixel_value_r = '0;
            draw_code_r   = '0;
            have_prev     = 1'b0;
            prev_x        = '0;
            prev_y        = '0;
            run_x         = '0;
            run_y         = '0;
            run_len       = 0;
            expected_words.delete();
        end else begin
            // result words against the oldest prediction
            if (i_item.valid && i_item.ready) begin
                seen.item_kind     = i_item.item_kind;
                seen.start_x       = i_item.start_x;
                seen.start_y       = i_item.start_y;
                seen.end_x         = i_item.end_x;
                seen.end_y         = i_item.end_y;
                seen.run_length    = i_item.run_length;
                seen.delta_x       = i_item.delta_x;
                seen.delta_y       = i_item.delta_y;
                seen.header_target = i_item.header_target;
                seen.header_value  = i_item.header_value;
                seen.header_code   = i_item.header_code;
                seen.last_of_burst = i_item.last_of_burst;
                if (expected_words.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    want = expected_words.pop_front();
                    compare_word(seen, want);
                end
                words_seen++;
            end
            // register writes
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_TARGET_ID:   target_id_r   = i_cfg.data[TARGET_W-1:0];
                    CFG_PIXEL_VALUE: pixel_value_r = i_cfg.data[VALUE_W-1:0];
                    CFG_DRAW_CODE:   draw_code_r   = i_cfg.data[CODE_W-1:0];
                    default: ;
                endcase
            end
            // accepted vertex
            if (i_pt.valid && i_pt.ready)
                encode_vertex(i_pt.point_x, i_pt.point_y, i_pt.last_point);
        end
        o_outstanding <= expected_words.size();
        o_fail_count  <= mismatches;
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the polyline delta run encoder with directed polylines, then random
// polylines over several register settings, with random gaps on the vertex
// side and random stalls on the result side. The checker beside the block
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
    import pdre_pkg::*;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int PHASE_VERTICES  = 65;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int fail_count;
    int outstanding;
    int quiet_cycles = 0;
    int vertices_sent = 0;
    bit sender_steady = 1'b0;
    bit hold_off_request = 1'b0;

    pdre_in_if  pt_ch ();
    pdre_out_if item_ch ();
    pdre_cfg_if cfg_ch ();

    polyline_delta_run_encoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_ch),
        .o_item  (item_ch),
        .i_cfg   (cfg_ch)
    );

    pdre_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pt          (pt_ch),
        .i_item        (item_ch),
        .i_cfg         (cfg_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #10 i_clk = ~i_clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // step that fits a byte, extremes now and then
    function automatic logic signed [COORD_W-1:0] short_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 127;
        if (r < 12)
            return -128;
        return $urandom_range(0, 255) - 128;
    endfunction

    // step just outside or a little past the byte range
    function automatic logic signed [COORD_W-1:0] boundary_step();
        case ($urandom_range(0, 3))
            0: return 128;
            1: return -129;
            2: return $urandom_range(129, 400);
            default: return -$urandom_range(130, 400);
        endcase
    endfunction

    // start points, some close to the wrap of the coordinate range
    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFF80 + $urandom_range(0, 127);
            1: return 32'sh80000000 + $urandom_range(0, 127);
            default: return $urandom;
        endcase
    endfunction

    // one vertex word, held until accepted
    task automatic send_vertex(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y,
                               input logic last);
        int gap;
        gap = pick_gap(sender_steady);
        if (gap > 0) begin
            pt_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pt_ch.valid      <= 1'b1;
        pt_ch.point_x    <= x;
        pt_ch.point_y    <= y;
        pt_ch.last_point <= last;
        do @(posedge i_clk); while (pt_ch.ready !== 1'b1);
        vertices_sent++;
    endtask

    task automatic send_polyline(input int count, input bit all_short);
        logic signed [COORD_W-1:0] x, y, sx, sy;
        int r;
        x = pick_coord();
        y = pick_coord();
        for (int k = 0; k < count; k++) begin
            if (k > 0) begin
                sx = short_step();
                sy = short_step();
                r  = $urandom_range(0, 99);
                if (!all_short) begin
                    if (r < 12) begin
                        sx = $urandom;
                        sy = $urandom;
                    end else if (r < 22) begin
                        if (r[0])
                            sx = boundary_step();
                        else
                            sy = boundary_step();
                    end
                end
                x = x + sx;
                y = y + sy;
            end
            send_vertex(x, y, k == count - 1);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [TARGET_W-1:0] target,
                                  input logic [VALUE_W-1:0] value,
                                  input logic [CODE_W-1:0] code);
        write_reg(CFG_TARGET_ID, CFG_DATA_W'(target));
        write_reg(CFG_PIXEL_VALUE, CFG_DATA_W'(value));
        write_reg(CFG_DRAW_CODE, CFG_DATA_W'(code));
    endtask

    // stop offering, wait for every predicted word, then let the block go idle
    task automatic settle();
        pt_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // result side: random stalls, calm stretches and one long hold-off
    initial begin : result_sink
        int stall_left;
        int mode_left;
        bit steady;
        bit hold_off_taken;
        stall_left     = 0;
        mode_left      = 0;
        steady         = 1'b0;
        hold_off_taken = 1'b0;
        item_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (mode_left == 0) begin
                steady    = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(20, 100);
            end else begin
                mode_left--;
            end
            if (stall_left > 0) begin
                stall_left--;
                item_ch.ready <= 1'b0;
            end else if (hold_off_request && !hold_off_taken) begin
                hold_off_taken = 1'b1;
                stall_left = HOLD_OFF_CYCLES - 1;
                item_ch.ready <= 1'b0;
            end else if (steady || $urandom_range(0, 99) < 65) begin
                item_ch.ready <= 1'b1;
            end else begin
                stall_left = pick_gap(1'b0);
                item_ch.ready <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no word moving on any channel
    always @(posedge i_clk) begin
        if ((pt_ch.valid && pt_ch.ready) || (item_ch.valid && item_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("polyline_delta_run_encoder verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus
    initial begin : stimulus
        int len;
        int r;
        bit dense;
        pt_ch.valid      <= 1'b0;
        pt_ch.point_x    <= '0;
        pt_ch.point_y    <= '0;
        pt_ch.last_point <= 1'b0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.index     <= CFG_TARGET_ID;
        cfg_ch.data      <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_settings(16'h1234, 8'hA5, 16'hC3C3);

        // single vertex polyline, nothing comes out
        send_vertex(5, 5, 1'b1);
        // byte extremes, then a step of 128, then wrapped differences
        send_vertex(0, 0, 1'b0);
        send_vertex(127, -128, 1'b0);
        send_vertex(-1, -1, 1'b0);
        send_vertex(127, -1, 1'b0);
        send_vertex(32'sh80000000, 32'sh7FFFFFFF, 1'b0);
        send_vertex(32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0);
        send_vertex(32'sh7FFFFF80, 32'sh7FFFFFFF, 1'b0);
        send_vertex(32'sh7FFFFF80, 32'sh80000000, 1'b1);
        // long segments with no run in between
        send_vertex(100, 100, 1'b0);
        send_vertex(100, 400, 1'b0);
        send_vertex(0, 0, 1'b1);
        // long step first, then a run closed by the last vertex, zero step too
        send_vertex(0, 0, 1'b0);
        send_vertex(0, -129, 1'b0);
        send_vertex(1, -129, 1'b0);
        send_vertex(2, -127, 1'b0);
        send_vertex(2, -127, 1'b0);
        send_vertex(3, -126, 1'b1);

        // random polylines over several register settings
        for (int phase = 0; phase < 4; phase++) begin
            settle();
            case (phase)
                0: write_settings(16'($urandom), 8'($urandom), 16'($urandom));
                1: write_settings(16'hFFFF, 8'hFF, 16'hFFFF);
                2: write_settings(16'h0000, 8'h00, 16'h0000);
                default: write_settings(16'($urandom), 8'($urandom), 16'($urandom));
            endcase
            if (phase == 1) begin
                // result side holds off while a full run piles up behind it
                sender_steady    = 1'b1;
                hold_off_request = 1'b1;
                send_polyline(40, 1'b1);
            end
            vertices_sent = 0;
            while (vertices_sent < PHASE_VERTICES) begin
                r = $urandom_range(0, 99);
                if (r < 8)
                    len = 1;
                else if (r < 78)
                    len = $urandom_range(2, 10);
                else if (r < 90)
                    len = $urandom_range(11, 24);
                else
                    len = $urandom_range(30, 45);
                dense = ($urandom_range(0, 3) == 0) || (len >= 30);
                sender_steady = ($urandom_range(0, 4) == 0);
                send_polyline(len, dense);
            end
        end

        settle();
        if (fail_count == 0)
            $display("polyline_delta_run_encoder verification clean");
        else
            $display("polyline_delta_run_encoder verification failed");
        $finish;
    end

endmodule
